// ===== design/mrrc_pkg.sv =====
// Package with shared types, status codes and the CRC byte update for the response checker.
`timescale 1ns / 1ps
`default_nettype none

package mrrc_pkg;

    localparam logic [2:0] ST_BUSY = 3'd0;
    localparam logic [2:0] ST_OK   = 3'd1;
    localparam logic [2:0] ST_ADDR = 3'd2;
    localparam logic [2:0] ST_FUNC = 3'd3;
    localparam logic [2:0] ST_CRC  = 3'd4;

    localparam logic [7:0]  FUNC_READ_REGS = 8'd3;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [7:0]  NODE_RESET     = 8'd1;

    typedef struct packed {
        logic [2:0] status;
        logic       payload_valid;
        logic [7:0] payload_byte;
    } mrrc_result_t;

    // Reflected CRC-16 over one byte, LSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ===== design/modbus_read_response_checker_unit.sv =====
// Top level of the Modbus read-registers response checker with handshake and node register.
`timescale 1ns / 1ps
`default_nettype none

// Checks a Modbus RTU read-registers response one received byte per transaction and
// returns one result per byte: the sticky frame status, and the byte itself when it is
// a data byte. A new byte can be taken every clock cycle unless the input is stalled;
// each result is registered on acceptance, shows in the next cycle and stays in an output
// register until it is taken, so input stall follows output stall only while that register
// is full. The rate rests on the combinational CRC-16 byte update ahead of that register.
// The expected node register resets to 1 and should be written only while the checker
// is idle; it is compared against the first byte of each frame.

module modbus_read_response_checker_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    input  wire logic       frame_start,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      status,
    output logic            payload_valid,
    output logic [7:0]      payload_byte
);

    logic [7:0]             expected_node_reg;
    logic                   out_valid_reg, out_valid_next;
    logic                   accept;
    mrrc_pkg::mrrc_result_t result;

    assign in_stall       = out_valid_reg && out_stall;
    assign accept         = in_valid && !in_stall;
    assign out_valid_next = accept || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_node_reg <= mrrc_pkg::NODE_RESET;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                expected_node_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    mrrc_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .rx_byte       (rx_byte),
        .frame_start   (frame_start),
        .expected_node (expected_node_reg),
        .result        (result)
    );

    assign out_valid     = out_valid_reg;
    assign status        = result.status;
    assign payload_valid = result.payload_valid;
    assign payload_byte  = result.payload_byte;

`ifndef ASSERT_OFF
    // Every accepted byte must leave a result in the output register.
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted transaction produced no result");

    // The input side is held back only by a pending, stalled result.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output register");

    // A data byte can only occur while the frame is still in progress.
    a_payload_in_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && payload_valid) |-> (status == mrrc_pkg::ST_BUSY))
        else $error("payload byte with a final status");

    // Non-data results carry a zero byte.
    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !payload_valid) |-> (payload_byte == 8'd0))
        else $error("payload byte nonzero without payload_valid");
`endif

endmodule

`default_nettype wire

// ===== design/mrrc_parser.sv =====
// Frame parser: phase tracking, CRC accumulation and the result register.
`timescale 1ns / 1ps
`default_nettype none

module mrrc_parser (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic [7:0]            rx_byte,
    input  wire logic                  frame_start,
    input  wire logic [7:0]            expected_node,
    output mrrc_pkg::mrrc_result_t     result
);

    typedef enum logic [2:0] {
        PH_ADDR,
        PH_FUNC,
        PH_COUNT,
        PH_DATA,
        PH_CRC_LO,
        PH_CRC_HI,
        PH_DONE
    } phase_t;

    phase_t                 phase_reg, phase_next, phase_cur;
    logic [15:0]            crc_reg, crc_next, crc_cur;
    logic [7:0]             left_reg, left_next, left_cur;
    logic [7:0]             low_reg, low_next, low_cur;
    logic [2:0]             sticky_reg, sticky_next, sticky_cur;
    mrrc_pkg::mrrc_result_t result_reg, result_next;
    logic [15:0]            crc_upd;
    logic [7:0]             left_dec;

    always_comb
    begin
        // A frame start abandons whatever frame was in progress.
        phase_cur  = frame_start ? PH_ADDR : phase_reg;
        crc_cur    = frame_start ? mrrc_pkg::CRC_INIT : crc_reg;
        left_cur   = frame_start ? 8'd0 : left_reg;
        low_cur    = frame_start ? 8'd0 : low_reg;
        sticky_cur = frame_start ? mrrc_pkg::ST_BUSY : sticky_reg;

        crc_upd  = mrrc_pkg::crc16_byte(crc_cur, rx_byte);
        left_dec = left_cur - 8'd1;

        phase_next  = phase_cur;
        crc_next    = crc_cur;
        left_next   = left_cur;
        low_next    = low_cur;
        sticky_next = sticky_cur;
        result_next.payload_valid = 1'b0;

        case (phase_cur)
            PH_ADDR:
            begin
                crc_next = crc_upd;
                if (rx_byte != expected_node)
                begin
                    sticky_next = mrrc_pkg::ST_ADDR;
                    phase_next  = PH_DONE;
                end
                else
                begin
                    phase_next = PH_FUNC;
                end
            end
            PH_FUNC:
            begin
                crc_next = crc_upd;
                if (rx_byte != mrrc_pkg::FUNC_READ_REGS)
                begin
                    sticky_next = mrrc_pkg::ST_FUNC;
                    phase_next  = PH_DONE;
                end
                else
                begin
                    phase_next = PH_COUNT;
                end
            end
            PH_COUNT:
            begin
                crc_next   = crc_upd;
                left_next  = rx_byte;
                phase_next = (rx_byte == 8'd0) ? PH_CRC_LO : PH_DATA;
            end
            PH_DATA:
            begin
                crc_next  = crc_upd;
                left_next = left_dec;
                result_next.payload_valid = 1'b1;
                if (left_dec == 8'd0)
                begin
                    phase_next = PH_CRC_LO;
                end
            end
            PH_CRC_LO:
            begin
                low_next   = rx_byte;
                phase_next = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                sticky_next = ({rx_byte, low_cur} == crc_cur) ? mrrc_pkg::ST_OK
                                                              : mrrc_pkg::ST_CRC;
                phase_next  = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        result_next.status       = sticky_next;
        result_next.payload_byte = result_next.payload_valid ? rx_byte : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_ADDR;
            crc_reg    <= mrrc_pkg::CRC_INIT;
            left_reg   <= 8'd0;
            low_reg    <= 8'd0;
            sticky_reg <= mrrc_pkg::ST_BUSY;
            result_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            crc_reg    <= crc_next;
            left_reg   <= left_next;
            low_reg    <= low_next;
            sticky_reg <= sticky_next;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire
